[rtl/tpcc_pkg.sv]
// shared types, constants and a clamp helper for the texture pixel convert and crop block
// no dependencies
package tpcc_pkg;

    localparam int PIXEL_W   = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_MODE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_W    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_H    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_W      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_H      = 3'd4;

    // conversion modes, the unused code behaves as pass-through
    localparam logic [1:0] MODE_PASS  = 2'd0;
    localparam logic [1:0] MODE_SWAP  = 2'd1;
    localparam logic [1:0] MODE_YCOCG = 2'd2;

    localparam logic [7:0] CHROMA_BIAS = 8'd128;
    localparam logic [7:0] BYTE_MAX    = 8'd255;

    // controller to datapath
    typedef struct packed {
        logic capture;    // take the pixel, step the raster counters
        logic div_start;  // start the chroma dividers on the accepted pixel
        logic load_out;   // move the converted pixel into the output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic kept;       // current raster position lies inside the crop
        logic need_div;   // mode needs the chroma dividers
        logic div_done;   // quotients ready
    } t_status;

    function automatic logic [7:0] clamp_byte(input logic signed [10:0] v);
        logic [7:0] res;
        if (v > 11'sd255) begin
            res = BYTE_MAX;
        end else if (v < 11'sd0) begin
            res = 8'd0;
        end else begin
            res = v[7:0];
        end
        return res;
    endfunction

endpackage

[rtl/tpcc_div.sv]
// bit-serial signed divider for one chroma channel, (byte - 128) / divisor
// truncating toward zero; depends on tpcc_pkg
module tpcc_div
    import tpcc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [7:0]        i_byte,
    input  logic [4:0]        i_scale,
    output logic              o_done,
    output logic signed [8:0] o_quot
);

    logic       r_busy, n_busy;
    logic       r_done, n_done;
    logic [2:0] r_cnt, n_cnt;
    logic [4:0] r_rem, n_rem;
    logic [7:0] r_quo, n_quo;
    logic [5:0] r_div, n_div;
    logic       r_neg, n_neg;

    logic [5:0] w_rem_sh;
    logic [5:0] w_rem_sub;
    logic       w_fits;
    logic [7:0] w_mag;
    logic       w_neg;

    // magnitude and sign of the biased byte
    always_comb begin
        w_neg = (i_byte < CHROMA_BIAS);
        w_mag = w_neg ? (CHROMA_BIAS - i_byte) : (i_byte - CHROMA_BIAS);
    end

    // restoring step: shift one dividend bit into the remainder
    always_comb begin
        w_rem_sh  = {r_rem, r_quo[7]};
        w_fits    = (w_rem_sh >= r_div);
        w_rem_sub = w_rem_sh - r_div;
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_div  = r_div;
        n_neg  = r_neg;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = 3'd0;
            n_rem  = 5'd0;
            n_quo  = w_mag;
            n_div  = {1'b0, i_scale} + 6'd1;
            n_neg  = w_neg;
        end else if (r_busy) begin
            n_rem = w_fits ? w_rem_sub[4:0] : w_rem_sh[4:0];
            n_quo = {r_quo[6:0], w_fits};
            n_cnt = r_cnt + 3'd1;
            if (r_cnt == 3'd7) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 3'd0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_div <= n_div;
        r_neg <= n_neg;
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});

endmodule

[rtl/tpcc_dpath.sv]
// datapath: configuration registers, raster counters, crop test, color conversion
// and output register; depends on tpcc_pkg and tpcc_div
module tpcc_dpath
    import tpcc_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [PIXEL_W-1:0]    i_pixel,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    output logic [PIXEL_W-1:0]    o_out_data,
    output logic                  o_out_last
);

    localparam logic [COORD_BITS-1:0] CoordOne = COORD_BITS'(1);

    logic [1:0]            r_mode;
    logic [CFG_DATA_W-1:0] r_src_w, r_src_h, r_fill_w, r_fill_h;

    logic [COORD_BITS-1:0] r_col, n_col;
    logic [COORD_BITS-1:0] r_row, n_row;

    logic [PIXEL_W-1:0]    r_pix;
    logic                  r_last;
    logic [PIXEL_W-1:0]    r_out_data;
    logic                  r_out_last;

    logic [COORD_BITS-1:0] w_sw, w_sh, w_fw, w_fh, w_cw, w_ch;
    logic                  w_kept, w_last;

    logic                  w_done_co, w_done_cg;
    logic signed [8:0]     w_co, w_cg;
    logic signed [10:0]    w_y, w_co_x, w_cg_x;
    logic [7:0]            w_r, w_g, w_b, w_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_PASS;
            r_src_w  <= CFG_DATA_W'(1);
            r_src_h  <= CFG_DATA_W'(1);
            r_fill_w <= '0;
            r_fill_h <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MODE:     r_mode   <= i_cfg_data[1:0];
                CFG_SOURCE_W: r_src_w  <= i_cfg_data;
                CFG_SOURCE_H: r_src_h  <= i_cfg_data;
                CFG_FILL_W:   r_fill_w <= i_cfg_data;
                CFG_FILL_H:   r_fill_h <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // effective source and crop sizes
    always_comb begin
        w_sw = (r_src_w[COORD_BITS-1:0] == '0) ? CoordOne : r_src_w[COORD_BITS-1:0];
        w_sh = (r_src_h[COORD_BITS-1:0] == '0) ? CoordOne : r_src_h[COORD_BITS-1:0];
        w_fw = r_fill_w[COORD_BITS-1:0];
        w_fh = r_fill_h[COORD_BITS-1:0];
        w_cw = ((w_fw != '0) && (w_fw <= w_sw)) ? w_fw : w_sw;
        w_ch = ((w_fh != '0) && (w_fh <= w_sh)) ? w_fh : w_sh;
        w_kept = (r_col < w_cw) && (r_row < w_ch);
        w_last = (r_col == w_cw - CoordOne) && (r_row == w_ch - CoordOne);
    end

    // raster walk, wraps at the end of a row and of the image
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_cmd.capture) begin
            if (r_col >= w_sw - CoordOne) begin
                n_col = '0;
                n_row = (r_row >= w_sh - CoordOne) ? '0 : r_row + CoordOne;
            end else begin
                n_col = r_col + CoordOne;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_pix  <= i_pixel;
            r_last <= w_last;
        end
        if (i_cmd.load_out) begin
            r_out_data <= {w_a, w_b, w_g, w_r};
            r_out_last <= r_last;
        end
    end

    tpcc_div u_div_co (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_byte  (i_pixel[7:0]),
        .i_scale (i_pixel[23:19]),
        .o_done  (w_done_co),
        .o_quot  (w_co)
    );

    tpcc_div u_div_cg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_byte  (i_pixel[15:8]),
        .i_scale (i_pixel[23:19]),
        .o_done  (w_done_cg),
        .o_quot  (w_cg)
    );

    // channel selection per mode
    always_comb begin
        w_y    = $signed({3'b000, r_pix[31:24]});
        w_co_x = 11'(w_co);
        w_cg_x = 11'(w_cg);
        case (r_mode)
            MODE_SWAP: begin
                w_r = r_pix[23:16];
                w_g = r_pix[15:8];
                w_b = r_pix[7:0];
                w_a = r_pix[31:24];
            end
            MODE_YCOCG: begin
                w_r = clamp_byte(w_y + w_co_x - w_cg_x);
                w_g = clamp_byte(w_y + w_cg_x);
                w_b = clamp_byte(w_y - w_co_x - w_cg_x);
                w_a = BYTE_MAX;
            end
            default: begin
                w_r = r_pix[7:0];
                w_g = r_pix[15:8];
                w_b = r_pix[23:16];
                w_a = r_pix[31:24];
            end
        endcase
    end

    assign o_status.kept     = w_kept;
    assign o_status.need_div = (r_mode == MODE_YCOCG);
    assign o_status.div_done = w_done_co & w_done_cg;
    assign o_out_data        = r_out_data;
    assign o_out_last        = r_out_last;

endmodule

[rtl/tpcc_ctrl.sv]
// controller: sequences accept, divide and output load, owns the output valid flag
// depends on tpcc_pkg
module tpcc_ctrl
    import tpcc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_PUSH = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       w_accept;
    logic       w_out_free;

    assign w_accept   = (r_state == ST_IDLE) && i_in_valid;
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state         = r_state;
        o_cmd.capture   = 1'b0;
        o_cmd.div_start = 1'b0;
        o_cmd.load_out  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    o_cmd.capture = 1'b1;
                    if (i_status.kept) begin
                        if (i_status.need_div) begin
                            o_cmd.div_start = 1'b1;
                            n_state         = ST_DIV;
                        end else begin
                            n_state = ST_PUSH;
                        end
                    end
                end
            end
            ST_DIV: begin
                if (i_status.div_done) begin
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (w_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

[rtl/texture_pixel_convert_crop.sv]
// texture pixel convert and crop, top level: stream ports, controller and datapath
// depends on tpcc_pkg, tpcc_ctrl, tpcc_dpath, tpcc_div
// pass-through and swap: the pixel is captured at accept, then the push state loads the output
// register; no new item is accepted until then. scaled ycocg: two 8-step bit-serial dividers
//   set the pace, push waits for both quotients; a cropped-out item frees the input next cycle
// reset: synchronous active low, registers to mode 0, source 1x1, no crop, counters zero
module texture_pixel_convert_crop
    import tpcc_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port, no read-back
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // pixel input
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [PIXEL_W-1:0]    s_axis_tdata,  // byte_zero, byte_one, byte_two, byte_three
    // converted pixel output
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [PIXEL_W-1:0]    m_axis_tdata,  // out_red, out_green, out_blue, out_alpha
    output logic                  m_axis_tlast   // last_pixel
);

    t_cmd    w_cmd;
    t_status w_status;

    // controller: idle accepts, divide waits on the dividers, push fills the
    // output register as soon as it is empty or being drained
    tpcc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // datapath: raster counters decide keep and last at accept, conversion is
    // computed from the captured pixel and the quotients
    tpcc_dpath #(
        .COORD_BITS (COORD_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pixel     (s_axis_tdata),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_data  (m_axis_tdata),
        .o_out_last  (m_axis_tlast)
    );

    // a result never overwrites one that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> (!m_axis_tvalid || m_axis_tready))
        else $error("output register overwritten while stalled");

    // no new item while the dividers run
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.div_start |=> !s_axis_tready)
        else $error("input ready during division");

    // quotients only finish while the controller waits for them
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.div_done |-> !s_axis_tready)
        else $error("divider finished outside the divide phase");

    // a loaded result is presented on the next cycle
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |=> m_axis_tvalid)
        else $error("loaded result not presented");

endmodule

[dv/tb_texture_pixel_convert_crop.sv]
`timescale 1ns / 100ps
// self-checking testbench for texture_pixel_convert_crop: stream driver, output monitor, predictor
// depends on tpcc_pkg and the texture_pixel_convert_crop rtl
module tb_texture_pixel_convert_crop;
    import tpcc_pkg::*;

    // codes the package leaves unnamed: the spare mode and an unmapped register slot
    localparam logic [1:0]           MODE_UNUSED  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd5;

    localparam int RANDOM_ITEMS   = 1000;
    localparam int SETTLE_CYCLES  = 24;    // idle time after the queues drain, before the next phase
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;

    // input item, byte_zero in the low bits as on s_axis_tdata
    typedef struct packed {
        logic [7:0] byte_three;
        logic [7:0] byte_two;
        logic [7:0] byte_one;
        logic [7:0] byte_zero;
    } t_pixel;

    // result item, red in the low bits as on m_axis_tdata
    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_rgba;

    typedef struct packed {
        t_rgba color;
        logic  last;
    } t_kept_pixel;

    // every input known from time zero
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [PIXEL_W-1:0]    s_axis_tdata  = '0;  // byte_zero, byte_one, byte_two, byte_three
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [PIXEL_W-1:0]    m_axis_tdata;        // out_red, out_green, out_blue, out_alpha
    logic                  m_axis_tlast;        // last_pixel

    texture_pixel_convert_crop dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // predictor: shadow registers and raster position, reset values
    // ------------------------------------------------------------------
    logic [1:0]  mode_q   = MODE_PASS;
    logic [15:0] src_w_q  = 16'd1;
    logic [15:0] src_h_q  = 16'd1;
    logic [15:0] fill_w_q = 16'd0;
    logic [15:0] fill_h_q = 16'd0;
    logic [15:0] col_q    = 16'd0;
    logic [15:0] row_q    = 16'd0;

    t_pixel      pending_q[$];   // items waiting for the driver
    t_kept_pixel kept_q[$];      // converted pixels still owed by the block
    int          mismatches = 0;
    int          gap_max    = 0; // longest sender gap for the current phase

    function automatic logic [7:0] saturate(input int v);
        if (v > 255) return 8'hFF;
        if (v < 0) return 8'h00;
        return v[7:0];
    endfunction

    // steps the raster position; returns 1 and the converted pixel when it lies in the crop
    function automatic bit convert_and_crop(input t_pixel px, output t_kept_pixel res);
        int sw, sh, cw, ch, col, row, scale, co, cg, luma;
        sw  = (src_w_q == 16'd0) ? 1 : src_w_q;
        sh  = (src_h_q == 16'd0) ? 1 : src_h_q;
        // a fill larger than the source, or zero, leaves that dimension uncropped
        cw  = (fill_w_q != 16'd0 && fill_w_q <= sw) ? fill_w_q : sw;
        ch  = (fill_h_q != 16'd0 && fill_h_q <= sh) ? fill_h_q : sh;
        col = col_q;
        row = row_q;
        res = '0;
        // counters left beyond a shrunken size wrap on this pixel
        if (col >= sw - 1) begin
            col_q = '0;
            row_q = (row >= sh - 1) ? 16'd0 : 16'(row + 1);
        end else begin
            col_q = 16'(col + 1);
        end
        if (!(col < cw && row < ch)) return 1'b0;
        res.last = (col == cw - 1) && (row == ch - 1);
        case (mode_q)
            MODE_SWAP: begin
                res.color = '{alpha: px.byte_three, blue: px.byte_zero,
                              green: px.byte_one, red: px.byte_two};
            end
            MODE_YCOCG: begin
                scale = int'(px.byte_two >> 3) + 1;
                // sv integer division truncates toward zero
                co    = (int'(px.byte_zero) - 128) / scale;
                cg    = (int'(px.byte_one) - 128) / scale;
                luma  = int'(px.byte_three);
                res.color = '{alpha: 8'hFF, blue: saturate(luma - co - cg),
                              green: saturate(luma + cg), red: saturate(luma + co - cg)};
            end
            default: begin
                // pass-through, the spare mode included
                res.color = '{alpha: px.byte_three, blue: px.byte_two,
                              green: px.byte_one, red: px.byte_zero};
            end
        endcase
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // driver: bursts of random length with random gaps, valid held until taken
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge i_clk) begin : driver
        t_kept_pixel res;
        logic        busy;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            busy = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                if (convert_and_crop(s_axis_tdata, res)) kept_q.push_back(res);
                busy = 1'b0;
            end
            if (!busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_q.size() > 0) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pending_q.pop_front();
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 15);
                        gap_left   = $urandom_range(0, gap_max);
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: stall style, re-picked at random, is one of
    // always ready, coin flip, mostly stalled, or a fixed 2-of-5 pattern
    // ------------------------------------------------------------------
    int ready_cycle = 0;
    int ready_style = 0;

    always @(posedge i_clk) begin : receiver
        ready_cycle++;
        if (ready_cycle % 200 == 0) ready_style = $urandom_range(0, 3);
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            case (ready_style)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= 1'($urandom_range(0, 1));
                2:       m_axis_tready <= ($urandom_range(0, 7) == 0);
                default: m_axis_tready <= (ready_cycle % 5) < 2;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // monitor: each output item against the oldest owed pixel
    // ------------------------------------------------------------------
    function automatic string describe(input t_kept_pixel p);
        return $sformatf("r %0d g %0d b %0d a %0d last %0d", p.color.red, p.color.green,
                         p.color.blue, p.color.alpha, p.last);
    endfunction

    task automatic report_mismatch(input string why, input t_kept_pixel want,
                                   input t_kept_pixel got);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("%0t %s: expected %s, got %s", $realtime, why, describe(want),
                     describe(got));
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_kept_pixel want;
        t_kept_pixel got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata, m_axis_tlast};
            if (kept_q.size() == 0) begin
                report_mismatch("result with nothing owed", '0, got);
            end else begin
                want = kept_q.pop_front();
                if (got.color.red !== want.color.red || got.color.green !== want.color.green ||
                    got.color.blue !== want.color.blue ||
                    got.color.alpha !== want.color.alpha || got.last !== want.last) begin
                    report_mismatch("pixel mismatch", want, got);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: too long with no item moving on either side
    // ------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_texture_pixel_convert_crop NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // block drained: nothing queued, nothing on the input, nothing owed, then settle
    task automatic wait_drained();
        while (pending_q.size() != 0 || s_axis_tvalid || kept_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // one register write per cycle; shadow copy follows at the write edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        case (idx)
            CFG_MODE:     mode_q   = val[1:0];
            CFG_SOURCE_W: src_w_q  = val;
            CFG_SOURCE_H: src_h_q  = val;
            CFG_FILL_W:   fill_w_q = val;
            CFG_FILL_H:   fill_h_q = val;
            default: ;
        endcase
    endtask

    // writes the registers picked in sel (bit i for index i), mode upper bits are don't-care
    task automatic configure(input logic [1:0] mode, input logic [15:0] sw, input logic [15:0] sh,
                             input logic [15:0] fw, input logic [15:0] fh, input logic [4:0] sel);
        if (sel[0]) write_reg(CFG_MODE, {14'($urandom), mode});
        if (sel[1]) write_reg(CFG_SOURCE_W, sw);
        if (sel[2]) write_reg(CFG_SOURCE_H, sh);
        if (sel[3]) write_reg(CFG_FILL_W, fw);
        if (sel[4]) write_reg(CFG_FILL_H, fh);
        i_cfg_we <= 1'b0;
    endtask

    // mostly small images, now and then zero, mid-size or the widest
    function automatic logic [15:0] pick_dim();
        case ($urandom_range(0, 11))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(7, 300));
            default: return 16'($urandom_range(1, 6));
        endcase
    endfunction

    // none, exact, oversized or a true crop
    function automatic logic [15:0] pick_fill(input logic [15:0] src);
        int eff;
        eff = (src == 16'd0) ? 1 : src;
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'(eff);
            2:       return (eff < 65533) ? 16'(eff + $urandom_range(1, 3)) : 16'hFFFF;
            3:       return 16'hFFFF;
            default: return 16'($urandom_range(1, eff));
        endcase
    endfunction

    // random bytes, each now and then pinned to an extreme to hit the clamps
    function automatic t_pixel random_pixel();
        logic [31:0] v;
        v = $urandom;
        for (int k = 0; k < 4; k++) begin
            case ($urandom_range(0, 7))
                0:       v[8*k +: 8] = 8'h00;
                1:       v[8*k +: 8] = 8'hFF;
                default: ;
            endcase
        end
        return v;
    endfunction

    // ------------------------------------------------------------------
    // stimulus: directed part, then random phases of config plus pixels
    // ------------------------------------------------------------------
    initial begin : stimulus
        int          sent;
        longint      area;
        int          n_pix;
        logic [15:0] sw, sh;

        sent = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset setting is a 1x1 image: every pixel kept and marked last
        pending_q.push_back(32'h0000_0000);
        pending_q.push_back(32'hFFFF_FFFF);
        pending_q.push_back(32'h80FF_017F);
        wait_drained();

        // red and blue swap
        configure(MODE_SWAP, 16'd1, 16'd1, 16'd0, 16'd0, 5'b11111);
        pending_q.push_back(32'h1122_3344);
        pending_q.push_back(32'hFF00_FF00);
        wait_drained();

        // scaled ycocg: clamps at both ends, largest scale, truncation of negative chroma
        configure(MODE_YCOCG, 16'd1, 16'd1, 16'd0, 16'd0, 5'b00001);
        pending_q.push_back(32'h0000_FF00);
        pending_q.push_back(32'hFF00_00FF);
        pending_q.push_back(32'h80FF_0100);
        pending_q.push_back(32'h4017_8000);
        pending_q.push_back(32'hC808_8080);
        wait_drained();

        // spare mode falls back to pass-through
        configure(MODE_UNUSED, 16'd1, 16'd1, 16'd0, 16'd0, 5'b00001);
        pending_q.push_back(32'hA1B2_C3D4);
        wait_drained();

        // 3x2 source cropped to 2x1: two kept, second marked
        configure(MODE_PASS, 16'd3, 16'd2, 16'd2, 16'd1, 5'b11111);
        for (int k = 0; k < 6; k++) pending_q.push_back(random_pixel());
        wait_drained();

        // fill wider than the source is ignored, no crop at all
        configure(MODE_PASS, 16'd3, 16'd2, 16'd5, 16'd0, 5'b11000);
        for (int k = 0; k < 6; k++) pending_q.push_back(random_pixel());
        wait_drained();

        // a write to an unmapped slot, then zero source size counts as one
        write_reg(CFG_UNMAPPED, 16'hFFFF);
        configure(MODE_SWAP, 16'd0, 16'd0, 16'd0, 16'd0, 5'b11111);
        pending_q.push_back(32'h0102_0304);
        pending_q.push_back(32'hF0E0_D0C0);
        wait_drained();

        // widest source with fills at the widest; leaves counters beyond the next sizes
        configure(MODE_YCOCG, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 5'b11111);
        for (int k = 0; k < 40; k++) pending_q.push_back(random_pixel());
        sent += 40;
        wait_drained();

        while (sent < RANDOM_ITEMS) begin
            sw = pick_dim();
            sh = pick_dim();
            if ($urandom_range(0, 15) == 0) begin
                write_reg(3'($urandom_range(int'(CFG_UNMAPPED), 7)), 16'($urandom));
            end
            configure(2'($urandom_range(0, 3)), sw, sh, pick_fill(sw), pick_fill(sh),
                      ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'b11111);
            gap_max = $urandom_range(0, 6);
            // sizes as the block sees them after a partial write
            area = longint'((src_w_q == 16'd0) ? 1 : int'(src_w_q)) *
                   longint'((src_h_q == 16'd0) ? 1 : int'(src_h_q));
            if (area > 48)
                n_pix = $urandom_range(1, 60);
            else if ($urandom_range(0, 3) == 0)
                n_pix = $urandom_range(1, int'(area));
            else
                n_pix = $urandom_range(int'(area), 3 * int'(area));
            for (int k = 0; k < n_pix; k++) pending_q.push_back(random_pixel());
            sent += n_pix;
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && kept_q.size() == 0) begin
            $display("tb_texture_pixel_convert_crop OK");
        end else begin
            $display("tb_texture_pixel_convert_crop NOT OK");
        end
        $finish;
    end

endmodule

[texture_pixel_convert_crop.f]
rtl/tpcc_pkg.sv
rtl/tpcc_div.sv
rtl/tpcc_dpath.sv
rtl/tpcc_ctrl.sv
rtl/texture_pixel_convert_crop.sv
dv/tb_texture_pixel_convert_crop.sv
